// File: src/cc20_pkg.sv
// Shared types, constants and the quarter-round function for the ChaCha20
// keystream generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

  localparam int ROUND_COUNT = 20;
  localparam int RND_W       = $clog2(ROUND_COUNT);

  localparam int KEY_W   = 64;
  localparam int CNT_W   = 7;
  localparam int VB_W    = 4;
  localparam int CFG_IDX_W = 3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

  localparam logic [CNT_W-1:0] BLOCK_BYTES = 7'd64;

  // "expand 32-byte k"
  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  typedef logic [15:0][31:0] cc20_state_t;
  typedef logic [3:0][31:0]  cc20_quad_t;

  // one quarter round on (a, b, c, d); result packed as {d, c, b, a}
  function automatic cc20_quad_t quarter(input logic [31:0] a_in, input logic [31:0] b_in,
                                         input logic [31:0] c_in, input logic [31:0] d_in);
    logic [31:0] a, b, c, d, t;
    cc20_quad_t  res;
    a = a_in; b = b_in; c = c_in; d = d_in;
    a = a + b; t = d ^ a; d = {t[15:0], t[31:16]};
    c = c + d; t = b ^ c; b = {t[19:0], t[31:20]};
    a = a + b; t = d ^ a; d = {t[23:0], t[31:24]};
    c = c + d; t = b ^ c; b = {t[24:0], t[31:25]};
    res = {d, c, b, a};
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/cc20_if.sv
// Valid/ready channel interfaces for the ChaCha20 keystream generator:
// request, keystream word and config write. Depends on cc20_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cc20_in_if;
  logic                     valid;
  logic                     ready;
  logic                     restart;
  logic [cc20_pkg::CNT_W-1:0] byte_count;
  modport source (output valid, restart, byte_count, input ready);
  modport sink   (input valid, restart, byte_count, output ready);
endinterface

interface cc20_out_if;
  logic                      valid;
  logic                      ready;
  logic [cc20_pkg::KEY_W-1:0] keystream_word;
  logic [cc20_pkg::VB_W-1:0]  valid_bytes;
  logic                      last_word;
  modport source (output valid, keystream_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, keystream_word, valid_bytes, last_word, output ready);
endinterface

interface cc20_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cc20_pkg::CFG_IDX_W-1:0] index;
  logic [cc20_pkg::KEY_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/cc20_round.sv
// One ChaCha20 round: four quarter rounds on column or diagonal lanes.
// Depends on cc20_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cc20_round (
  input  wire cc20_pkg::cc20_state_t st_i,
  input  wire                        diag_i,
  output cc20_pkg::cc20_state_t      st_o
);

  cc20_pkg::cc20_quad_t res [4];

  // diagonal round = column round on rows 1..3 rotated left by 1, 2, 3
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      res[l] = cc20_pkg::quarter(
        st_i[l],
        diag_i ? st_i[4 + ((l + 1) & 3)]  : st_i[4 + l],
        diag_i ? st_i[8 + ((l + 2) & 3)]  : st_i[8 + l],
        diag_i ? st_i[12 + ((l + 3) & 3)] : st_i[12 + l]);
    end
    for (int l = 0; l < 4; l++) begin
      st_o[l]      = res[l][0];
      st_o[4 + l]  = diag_i ? res[(l + 3) & 3][1] : res[l][1];
      st_o[8 + l]  = diag_i ? res[(l + 2) & 3][2] : res[l][2];
      st_o[12 + l] = diag_i ? res[(l + 1) & 3][3] : res[l][3];
    end
  end

endmodule

`default_nettype wire

// File: src/chacha20_keystream_generator.sv
// ChaCha20 keystream generator (64-bit counter, 64-bit nonce), top level.
// A request runs through the round, add and emit states; the first word is
// registered in emit. A new request is taken only when idle, after the last
// word is loaded. The single round unit takes one round per cycle.
// Reset (rst_n, synchronous): sequencer, block counter and key/nonce cleared.
// Depends on cc20_pkg, cc20_if and cc20_round.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_keystream_generator (
  input  wire         clk,
  input  wire         rst_n,
  cc20_in_if.sink     in_if,
  cc20_out_if.source  out_if,
  cc20_cfg_if.sink    cfg_if
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [cc20_pkg::RND_W-1:0]      rnd_r;
  logic [2:0]                      word_r;
  logic [cc20_pkg::CNT_W-1:0]      count_r;
  logic [63:0]                     ctr_r;
  logic [63:0]                     key_r [4];
  logic [63:0]                     nonce_r;
  cc20_pkg::cc20_state_t           init_r, work_r, round_out, init_nxt;

  logic                            in_acc;
  logic [63:0]                     ctr_eff;
  logic [cc20_pkg::CNT_W-1:0]      count_sat;
  logic [cc20_pkg::CNT_W-1:0]      left;
  logic [cc20_pkg::VB_W-1:0]       vb;
  logic                            last;
  logic                            out_load;
  logic [63:0]                     word_sel, word_mask;

  logic                            out_valid_r;
  logic [63:0]                     out_word_r;
  logic [cc20_pkg::VB_W-1:0]       out_vb_r;
  logic                            out_last_r;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;

  assign ctr_eff   = in_if.restart ? 64'd0 : ctr_r;
  assign count_sat = (in_if.byte_count > cc20_pkg::BLOCK_BYTES) ?
                     cc20_pkg::BLOCK_BYTES : in_if.byte_count;

  always_comb begin
    init_nxt[3:0] = cc20_pkg::SIGMA;
    for (int i = 0; i < 4; i++) begin
      init_nxt[4 + 2 * i] = key_r[i][31:0];
      init_nxt[5 + 2 * i] = key_r[i][63:32];
    end
    init_nxt[12] = ctr_eff[31:0];
    init_nxt[13] = ctr_eff[63:32];
    init_nxt[14] = nonce_r[31:0];
    init_nxt[15] = nonce_r[63:32];
  end

  cc20_round u_round (
    .st_i   (work_r),
    .diag_i (rnd_r[0]),
    .st_o   (round_out)
  );

  // word selection and tail masking
  assign left     = count_r - {1'b0, word_r, 3'b000};
  assign last     = (left <= 7'd8);
  assign vb       = last ? left[cc20_pkg::VB_W-1:0] : 4'd8;
  assign word_sel = {work_r[{word_r, 1'b1}], work_r[{word_r, 1'b0}]};
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      word_mask[8 * j +: 8] = (4'(j) < vb) ? 8'hff : 8'h00;
    end
  end

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && (in_if.byte_count != '0)) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == cc20_pkg::RND_W'(cc20_pkg::ROUND_COUNT - 1)) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_EMIT;
      ST_EMIT:  if (out_load && last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      word_r      <= '0;
      ctr_r       <= '0;
      nonce_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          cc20_pkg::CFG_KEY0:  key_r[0] <= cfg_if.data;
          cc20_pkg::CFG_KEY1:  key_r[1] <= cfg_if.data;
          cc20_pkg::CFG_KEY2:  key_r[2] <= cfg_if.data;
          cc20_pkg::CFG_KEY3:  key_r[3] <= cfg_if.data;
          cc20_pkg::CFG_NONCE: nonce_r  <= cfg_if.data;
          default: ;
        endcase
      end

      if (in_acc) begin
        ctr_r  <= ctr_eff;
        rnd_r  <= '0;
        word_r <= '0;
      end
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 1'b1;
      // counter moves only after a full block
      if (state_r == ST_ADD && count_r == cc20_pkg::BLOCK_BYTES) ctr_r <= ctr_r + 64'd1;
      if (out_load) word_r <= word_r + 1'b1;

      if (out_load)          out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      init_r  <= init_nxt;
      work_r  <= init_nxt;
      count_r <= count_sat;
    end else if (state_r == ST_ROUND) begin
      work_r <= round_out;
    end else if (state_r == ST_ADD) begin
      for (int i = 0; i < 16; i++) work_r[i] <= work_r[i] + init_r[i];
    end
    if (out_load) begin
      out_word_r <= word_sel & word_mask;
      out_vb_r   <= vb;
      out_last_r <= last;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.keystream_word = out_word_r;
  assign out_if.valid_bytes    = out_vb_r;
  assign out_if.last_word      = out_last_r;

endmodule

`default_nettype wire

// File: test/tb_chacha20_keystream_generator.sv
// Self-checking testbench for chacha20_keystream_generator: directed and random
// block requests under several key/nonce settings and handshake idling mixes.
// Depends on cc20_pkg, cc20_if and the generator RTL.
`timescale 1ns / 1ps

module tb_chacha20_keystream_generator;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = cc20_pkg::ROUND_COUNT + 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_REGS       = int'(cc20_pkg::CFG_NONCE) + 1;

  typedef struct packed {
    logic [cc20_pkg::KEY_W-1:0] word;
    logic [cc20_pkg::VB_W-1:0]  nbytes;
    logic                       last;
  } ks_word_t;

  // Holds key/nonce/counter, builds the expected keystream words per request
  // and matches them against what comes out.
  class keystream_board;
    logic [cc20_pkg::KEY_W-1:0] regs [NUM_REGS];
    logic [63:0]                block_ctr;
    logic [31:0]                mix [16];
    ks_word_t                   pending [$];
    int                         mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      block_ctr  = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [cc20_pkg::CFG_IDX_W-1:0] idx,
                          logic [cc20_pkg::KEY_W-1:0] val);
      if (idx <= cc20_pkg::CFG_NONCE) regs[idx] = val;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void qround(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    function void make_block();
      logic [31:0] init [16];
      // "expand 32-byte k"
      init[0] = 32'h61707865;
      init[1] = 32'h3320646e;
      init[2] = 32'h79622d32;
      init[3] = 32'h6b206574;
      for (int i = cc20_pkg::CFG_KEY0; i <= cc20_pkg::CFG_KEY3; i++) begin
        init[4 + 2 * i] = regs[i][31:0];
        init[5 + 2 * i] = regs[i][63:32];
      end
      init[12] = block_ctr[31:0];
      init[13] = block_ctr[63:32];
      init[14] = regs[cc20_pkg::CFG_NONCE][31:0];
      init[15] = regs[cc20_pkg::CFG_NONCE][63:32];
      mix = init;
      // column round first; an odd count ends on a column round
      for (int r = 0; r < cc20_pkg::ROUND_COUNT; r++) begin
        if (r % 2 == 0) begin
          qround(0, 4, 8, 12); qround(1, 5, 9, 13);
          qround(2, 6, 10, 14); qround(3, 7, 11, 15);
        end else begin
          qround(0, 5, 10, 15); qround(1, 6, 11, 12);
          qround(2, 7, 8, 13); qround(3, 4, 9, 14);
        end
      end
      foreach (mix[i]) mix[i] += init[i];
    endfunction

    function void note_request(logic rs, logic [cc20_pkg::CNT_W-1:0] cnt);
      int       n;
      int       nwords;
      int       left;
      ks_word_t w;
      if (rs) block_ctr = '0;
      if (cnt == 0) return;
      n = (cnt > cc20_pkg::BLOCK_BYTES) ? int'(cc20_pkg::BLOCK_BYTES) : int'(cnt);
      make_block();
      nwords = (n + 7) / 8;
      for (int k = 0; k < nwords; k++) begin
        left     = n - 8 * k;
        w.nbytes = cc20_pkg::VB_W'((left > 8) ? 8 : left);
        w.word   = {mix[2 * k + 1], mix[2 * k]};
        // bytes past the end of a short tail word read as zero
        if (left < 8) w.word &= (64'd1 << (8 * left)) - 64'd1;
        w.last   = (k == nwords - 1);
        pending.push_back(w);
      end
      // only a full block advances the counter
      if (n == cc20_pkg::BLOCK_BYTES) block_ctr++;
    endfunction

    function void check_word(logic [cc20_pkg::KEY_W-1:0] word,
                             logic [cc20_pkg::VB_W-1:0] nbytes, logic last);
      ks_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected keystream word %h bytes %0d last %0b",
                 $time, word, nbytes, last);
        mismatches++;
        return;
      end
      exp_w = pending.pop_front();
      if (word !== exp_w.word) begin
        $display("%0t: keystream_word expected %h actual %h", $time, exp_w.word, word);
        mismatches++;
      end
      if (nbytes !== exp_w.nbytes) begin
        $display("%0t: valid_bytes expected %0d actual %0d", $time, exp_w.nbytes, nbytes);
        mismatches++;
      end
      if (last !== exp_w.last) begin
        $display("%0t: last_word expected %0b actual %0b", $time, exp_w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cc20_in_if  req_ch ();
  cc20_out_if ks_ch ();
  cc20_cfg_if cfg_ch ();

  chacha20_keystream_generator i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_ch),
    .out_if(ks_ch),
    .cfg_if(cfg_ch)
  );

  keystream_board board;
  int req_idle_pct = 0;
  int ks_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // keystream receiver: random stalls, or one long hold-off when asked
  initial begin
    ks_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        ks_ch.ready <= 1'b0;
      end else begin
        ks_ch.ready <= ($urandom_range(99) >= ks_stall_pct);
      end
    end
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (ks_ch.valid && ks_ch.ready)
        board.check_word(ks_ch.keystream_word, ks_ch.valid_bytes, ks_ch.last_word);
      if (req_ch.valid && req_ch.ready)
        board.note_request(req_ch.restart, req_ch.byte_count);
      if (cfg_ch.valid && cfg_ch.ready)
        board.set_reg(cfg_ch.index, cfg_ch.data);
      if ((ks_ch.valid && ks_ch.ready) || (req_ch.valid && req_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("chacha20_keystream_generator test failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic rs, input logic [cc20_pkg::CNT_W-1:0] cnt);
    if ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
    end
    req_ch.valid      <= 1'b1;
    req_ch.restart    <= rs;
    req_ch.byte_count <= cnt;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // mostly full blocks, some tails, a few saturating and empty requests
  task automatic send_random_request();
    int                         pick;
    logic [cc20_pkg::CNT_W-1:0] cnt;
    pick = $urandom_range(99);
    if (pick < 55)      cnt = cc20_pkg::BLOCK_BYTES;
    else if (pick < 85) cnt = cc20_pkg::CNT_W'($urandom_range(63, 1));
    else if (pick < 95) cnt = cc20_pkg::CNT_W'($urandom_range(127, 65));
    else                cnt = '0;
    send_request($urandom_range(99) < 8, cnt);
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    req_idle_pct = idle_pct;
    ks_stall_pct = stall_pct;
    repeat (n) send_random_request();
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_words_done();
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  task automatic write_reg(input logic [cc20_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cc20_pkg::KEY_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // key/nonce change only once the block is drained, empty requests included
  task automatic load_key(input logic [cc20_pkg::KEY_W-1:0] k0, k1, k2, k3, nonce);
    wait_words_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(cc20_pkg::CFG_KEY0, k0);
    write_reg(cc20_pkg::CFG_KEY1, k1);
    write_reg(cc20_pkg::CFG_KEY2, k2);
    write_reg(cc20_pkg::CFG_KEY3, k3);
    write_reg(cc20_pkg::CFG_NONCE, nonce);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    board = new();
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.restart    <= 1'b0;
    req_ch.byte_count <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= cc20_pkg::CFG_KEY0;
    cfg_ch.data       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, all-zero key and nonce from reset
    send_request(1'b1, cc20_pkg::BLOCK_BYTES);
    send_request(1'b0, cc20_pkg::BLOCK_BYTES);
    send_request(1'b0, 7'd1);
    send_request(1'b0, 7'd7);
    send_request(1'b0, 7'd8);
    send_request(1'b0, 7'd9);
    send_request(1'b0, 7'd15);
    send_request(1'b0, 7'd16);
    send_request(1'b0, 7'd63);
    send_request(1'b0, 7'd0);      // empty request, counter stays
    send_request(1'b0, cc20_pkg::BLOCK_BYTES);
    send_request(1'b1, 7'd0);      // empty request still clears the counter
    send_request(1'b0, cc20_pkg::BLOCK_BYTES);
    send_request(1'b0, 7'd65);     // saturates to a full block
    send_request(1'b0, 7'd127);
    send_request(1'b1, 7'd100);
    req_ch.valid <= 1'b0;

    load_key('1, '1, '1, '1, '1);
    send_request(1'b1, cc20_pkg::BLOCK_BYTES);
    send_request(1'b0, 7'd33);
    send_request(1'b0, cc20_pkg::BLOCK_BYTES);
    send_request(1'b0, 7'd2);
    req_ch.valid <= 1'b0;

    run_phase(60, 0, 0);
    load_key(rand64(), rand64(), rand64(), rand64(), rand64());
    run_phase(60, 66, 0);
    load_key(rand64(), rand64(), rand64(), rand64(), rand64());
    run_phase(60, 0, 66);
    load_key({4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}});
    run_phase(60, 32, 32);

    // receiver backs up while requests keep coming, then sender waits out the drain
    load_key(rand64(), rand64(), rand64(), rand64(), rand64());
    hold_request = 1'b1;
    run_phase(16, 0, 0);
    wait_words_done();
    run_phase(20, 32, 32);

    load_key('0, '0, '0, '0, '0);
    run_phase(20, 0, 0);

    wait_words_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("chacha20_keystream_generator test passed");
    end else begin
      $display("chacha20_keystream_generator test failed");
    end
    $finish;
  end

endmodule
